// File: rtl/sfia_pkg.sv
// Package for the smallest-free-ID allocator: sizing constants, controller
// states and the command/status groups between controller and datapath.
// No dependencies.
package sfia_pkg;

    localparam int MAX_ID     = 1023;
    localparam int HEAP_DEPTH = 1024;

    // Width of an ID on the request and result ports
    localparam int IDW       = 10;
    // Fresh counter runs 1 .. MAX_ID+1
    localparam int CNT_W     = $clog2(MAX_ID + 2);
    // Heap fill count runs 0 .. HEAP_DEPTH
    localparam int HCNT_W    = $clog2(HEAP_DEPTH + 1);
    localparam int HAW       = $clog2(HEAP_DEPTH);
    // Child index arithmetic: 2*pos+2 must not wrap
    localparam int CW        = HAW + 2;
    localparam int BMP_DEPTH = MAX_ID + 1;
    localparam int BMP_AW    = $clog2(BMP_DEPTH);
    // Common width for comparing an ID against the counter or MAX_ID
    localparam int XW        = (CNT_W > IDW) ? CNT_W : IDW;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FRESH,
        ST_ROOT,
        ST_LAST,
        ST_SD_L,
        ST_SD_R,
        ST_SD_CMP,
        ST_REL_CHK,
        ST_SU,
        ST_SU_CMP,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_ACCEPT,
        DP_FRESH,
        DP_ALLOC_ROOT,
        DP_ALLOC_LAST,
        DP_SD_LEFT,
        DP_SD_RIGHT,
        DP_SD_CMP,
        DP_REL_CHECK,
        DP_SU_STEP,
        DP_SU_CMP,
        DP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic req_release;
        logic heap_empty;
        logic root_ok;
        logic left_ok;
        logic sd_stop;
        logic rel_ok;
        logic at_top;
        logic su_stop;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/smallest_free_id_allocator_unit.sv
// Top level of the smallest-free-ID allocator: joins the sequencer and the
// datapath. Depends on sfia_pkg, sfia_ctrl and sfia_dpath.
//
// Usage:
//  - Request channel: i_in_valid / o_in_stall with i_cmd (0 allocate,
//    1 release) and i_release_id. A request is taken at a rising edge with
//    i_in_valid high and o_in_stall low.
//  - Result channel: o_out_valid / i_out_stall with o_granted_id,
//    o_exhausted and o_release_taken; one result per request, in order.
//  - Steps per request, from the accepting edge to the result, with the heap
//    RAM's single read port setting the pace:
//      allocate from the fresh counter: a fresh-counter step, then the result;
//      allocate from the heap: root read, last-entry fetch, then a left read,
//      right read and compare per level sifted down, until a compare stops it;
//      release: a bitmap check, then a parent read and compare per level
//      sifted up; an ignored one goes straight to the result.
//  - One request is in work at a time; the next is taken the cycle after
//    its result is loaded into the output register, so requests follow each
//    other at the pace of the steps above and a result may wait there meanwhile.
//  - After reset the in-heap bitmap is swept to zero, all 1024 entries
//    (MAX_ID + 1), with o_in_stall held high.
//  - When the receiver stalls, the result holds in the output register;
//    a finished request behind it waits until the register frees.
module smallest_free_id_allocator_unit import sfia_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_cmd,
    input  logic [IDW-1:0] i_release_id,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [IDW-1:0] o_granted_id,
    output logic           o_exhausted,
    output logic           o_release_taken
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: one step of the request per state
    sfia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: counters, heap, bitmap and the output register
    sfia_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_grp       (w_cmd),
        .o_sts           (w_sts),
        .i_cmd           (i_cmd),
        .i_release_id    (i_release_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_granted_id    (o_granted_id),
        .o_exhausted     (o_exhausted),
        .o_release_taken (o_release_taken)
    );

    // A taken request always lines up with the datapath latching it
    a_accept_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (w_cmd.op == DP_ACCEPT))
        else $error("request taken without datapath latch");

    // No request is taken while the bitmap sweep runs
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == DP_CLEAR) |-> o_in_stall)
        else $error("request taken during bitmap sweep");

    // An exhausted allocate carries no ID and no release flag
    a_exh_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_exhausted) |-> (o_granted_id == '0 && !o_release_taken))
        else $error("exhausted result carries an ID");

    // A taken release grants nothing
    a_rel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_release_taken) |-> (o_granted_id == '0 && !o_exhausted))
        else $error("release result carries an ID");

endmodule

// File: rtl/sfia_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sfia_ctrl.sv
// Sequencer of the smallest-free-ID allocator: walks clear, allocate,
// sift-down, release and sift-up steps. Depends on sfia_pkg.
module sfia_ctrl import sfia_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_sts.req_release) n_state = ST_REL_CHK;
                    else if (i_sts.heap_empty)      n_state = ST_FRESH;
                    else                            n_state = ST_ROOT;
                end
            end
            ST_FRESH:   n_state = ST_DONE;
            ST_ROOT:    n_state = i_sts.root_ok ? ST_LAST : ST_FRESH;
            ST_LAST:    n_state = ST_SD_L;
            ST_SD_L:    n_state = i_sts.left_ok ? ST_SD_R : ST_DONE;
            ST_SD_R:    n_state = ST_SD_CMP;
            ST_SD_CMP:  n_state = i_sts.sd_stop ? ST_DONE : ST_SD_L;
            ST_REL_CHK: n_state = i_sts.rel_ok ? ST_SU : ST_DONE;
            ST_SU:      n_state = i_sts.at_top ? ST_DONE : ST_SU_CMP;
            ST_SU_CMP:  n_state = i_sts.su_stop ? ST_DONE : ST_SU;
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.op = DP_NOP;
        unique case (r_state)
            ST_CLEAR:   o_cmd.op = DP_CLEAR;
            ST_IDLE:    o_cmd.op = i_in_valid ? DP_ACCEPT : DP_NOP;
            ST_FRESH:   o_cmd.op = DP_FRESH;
            ST_ROOT:    o_cmd.op = DP_ALLOC_ROOT;
            ST_LAST:    o_cmd.op = DP_ALLOC_LAST;
            ST_SD_L:    o_cmd.op = DP_SD_LEFT;
            ST_SD_R:    o_cmd.op = DP_SD_RIGHT;
            ST_SD_CMP:  o_cmd.op = DP_SD_CMP;
            ST_REL_CHK: o_cmd.op = DP_REL_CHECK;
            ST_SU:      o_cmd.op = DP_SU_STEP;
            ST_SU_CMP:  o_cmd.op = DP_SU_CMP;
            ST_DONE:    o_cmd.op = DP_LOAD_OUT;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// File: rtl/sfia_dpath.sv
// Datapath of the smallest-free-ID allocator: counters, heap and bitmap RAMs,
// sift registers and the output register. Depends on sfia_pkg and sfia_ram.
module sfia_dpath import sfia_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd_grp,
    output t_dp_sts        o_sts,
    input  logic           i_cmd,
    input  logic [IDW-1:0] i_release_id,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [IDW-1:0] o_granted_id,
    output logic           o_exhausted,
    output logic           o_release_taken
);

    logic [CNT_W-1:0]  r_cnt_fresh;
    logic [HCNT_W-1:0] r_heap_cnt;
    logic [BMP_AW-1:0] r_clr_addr;
    logic [IDW-1:0]    r_id;
    logic [HAW-1:0]    r_pos;
    logic [IDW-1:0]    r_val;
    logic [IDW-1:0]    r_lv;
    logic              r_rok;
    logic [IDW-1:0]    r_res_granted;
    logic              r_res_exh;
    logic              r_res_taken;
    logic              r_out_valid;
    logic [IDW-1:0]    r_out_granted;
    logic              r_out_exh;
    logic              r_out_taken;

    logic [CNT_W-1:0]  n_cnt_fresh;
    logic [HCNT_W-1:0] n_heap_cnt;
    logic [BMP_AW-1:0] n_clr_addr;
    logic [IDW-1:0]    n_id;
    logic [HAW-1:0]    n_pos;
    logic [IDW-1:0]    n_val;
    logic [IDW-1:0]    n_lv;
    logic              n_rok;
    logic [IDW-1:0]    n_res_granted;
    logic              n_res_exh;
    logic              n_res_taken;

    logic              h_we;
    logic [HAW-1:0]    h_waddr;
    logic [IDW-1:0]    h_wdata;
    logic [HAW-1:0]    h_raddr;
    logic [IDW-1:0]    h_rdata;
    logic              b_we;
    logic [BMP_AW-1:0] b_waddr;
    logic              b_wdata;
    logic [BMP_AW-1:0] b_raddr;
    logic              b_rdata;

    logic [CW-1:0]     w_left;
    logic [CW-1:0]     w_right;
    logic [CW-1:0]     w_cnt;
    logic              w_left_ok;
    logic              w_right_ok;
    logic              w_root_ok;
    logic              w_fresh_ok;
    logic              w_rel_ok;
    logic              w_up_swap;
    logic              w_pick_l;
    logic              w_pick_r;
    logic [IDW-1:0]    w_min_lv;
    logic [HAW-1:0]    w_parent;
    logic              w_out_free;
    logic              w_load_out;

    sfia_ram #(.WIDTH(IDW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    sfia_ram #(.WIDTH(1), .DEPTH(BMP_DEPTH)) u_bmp_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign w_left     = {1'b0, r_pos, 1'b1};
    assign w_right    = w_left + CW'(1);
    assign w_cnt      = CW'(r_heap_cnt);
    assign w_left_ok  = (w_left < w_cnt);
    assign w_right_ok = (w_right < w_cnt);
    assign w_parent   = (r_pos - HAW'(1)) >> 1;
    assign w_root_ok  = (XW'(h_rdata) < XW'(r_cnt_fresh));
    assign w_fresh_ok = (r_cnt_fresh <= CNT_W'(MAX_ID));
    assign w_rel_ok   = (r_id != '0) && (XW'(r_id) <= XW'(MAX_ID))
                        && (XW'(r_id) < XW'(r_cnt_fresh)) && !b_rdata
                        && (r_heap_cnt < HCNT_W'(HEAP_DEPTH));
    assign w_up_swap  = (r_val < h_rdata);

    // Sift-down choice: left only if strictly below the moving value,
    // right only if strictly below the smaller of the two
    assign w_pick_l   = (r_lv < r_val);
    assign w_min_lv   = w_pick_l ? r_lv : r_val;
    assign w_pick_r   = r_rok && (h_rdata < w_min_lv);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (i_cmd_grp.op == DP_LOAD_OUT) && w_out_free;

    always_comb begin
        o_sts.clr_done    = (r_clr_addr == BMP_AW'(BMP_DEPTH - 1));
        o_sts.req_release = i_cmd;
        o_sts.heap_empty  = (r_heap_cnt == '0);
        o_sts.root_ok     = w_root_ok;
        o_sts.left_ok     = w_left_ok;
        o_sts.sd_stop     = !w_pick_l && !w_pick_r;
        o_sts.rel_ok      = w_rel_ok;
        o_sts.at_top      = (r_pos == '0);
        o_sts.su_stop     = !w_up_swap;
        o_sts.out_free    = w_out_free;
    end

    always_comb begin
        n_cnt_fresh   = r_cnt_fresh;
        n_heap_cnt    = r_heap_cnt;
        n_clr_addr    = r_clr_addr;
        n_id          = r_id;
        n_pos         = r_pos;
        n_val         = r_val;
        n_lv          = r_lv;
        n_rok         = r_rok;
        n_res_granted = r_res_granted;
        n_res_exh     = r_res_exh;
        n_res_taken   = r_res_taken;
        h_we          = 1'b0;
        h_waddr       = r_pos;
        h_wdata       = r_val;
        h_raddr       = '0;
        b_we          = 1'b0;
        b_waddr       = BMP_AW'(r_id);
        b_wdata       = 1'b0;
        b_raddr       = BMP_AW'(r_id);

        unique case (i_cmd_grp.op)
            DP_NOP, DP_LOAD_OUT: begin
            end
            DP_CLEAR: begin
                b_we       = 1'b1;
                b_waddr    = r_clr_addr;
                n_clr_addr = r_clr_addr + BMP_AW'(1);
            end
            DP_ACCEPT: begin
                n_id          = i_release_id;
                b_raddr       = BMP_AW'(i_release_id);
                h_raddr       = '0;
                n_res_granted = '0;
                n_res_exh     = 1'b0;
                n_res_taken   = 1'b0;
            end
            DP_FRESH: begin
                if (w_fresh_ok) begin
                    n_res_granted = IDW'(r_cnt_fresh);
                    n_cnt_fresh   = r_cnt_fresh + CNT_W'(1);
                end else begin
                    n_res_exh = 1'b1;
                end
            end
            DP_ALLOC_ROOT: begin
                // Take the root, fetch the last entry to refill the top
                if (w_root_ok) begin
                    n_res_granted = h_rdata;
                    n_heap_cnt    = r_heap_cnt - HCNT_W'(1);
                    h_raddr       = HAW'(r_heap_cnt - HCNT_W'(1));
                    b_we          = 1'b1;
                    b_waddr       = BMP_AW'(h_rdata);
                    b_wdata       = 1'b0;
                end
            end
            DP_ALLOC_LAST: begin
                n_val = h_rdata;
                n_pos = '0;
            end
            DP_SD_LEFT: begin
                if (w_left_ok) begin
                    h_raddr = HAW'(w_left);
                end else begin
                    h_we = 1'b1;
                end
            end
            DP_SD_RIGHT: begin
                n_lv    = h_rdata;
                n_rok   = w_right_ok;
                h_raddr = HAW'(w_right);
            end
            DP_SD_CMP: begin
                h_we = 1'b1;
                priority if (w_pick_r) begin
                    h_wdata = h_rdata;
                    n_pos   = HAW'(w_right);
                end else if (w_pick_l) begin
                    h_wdata = r_lv;
                    n_pos   = HAW'(w_left);
                end else begin
                    h_wdata = r_val;
                end
            end
            DP_REL_CHECK: begin
                if (w_rel_ok) begin
                    b_we        = 1'b1;
                    b_wdata     = 1'b1;
                    n_pos       = HAW'(r_heap_cnt);
                    n_heap_cnt  = r_heap_cnt + HCNT_W'(1);
                    n_val       = r_id;
                    n_res_taken = 1'b1;
                end
            end
            DP_SU_STEP: begin
                if (r_pos == '0) begin
                    h_we = 1'b1;
                end else begin
                    h_raddr = w_parent;
                end
            end
            DP_SU_CMP: begin
                h_we = 1'b1;
                if (w_up_swap) begin
                    h_wdata = h_rdata;
                    n_pos   = w_parent;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_fresh <= CNT_W'(1);
            r_heap_cnt  <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt_fresh <= n_cnt_fresh;
            r_heap_cnt  <= n_heap_cnt;
            r_clr_addr  <= n_clr_addr;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id          <= n_id;
        r_pos         <= n_pos;
        r_val         <= n_val;
        r_lv          <= n_lv;
        r_rok         <= n_rok;
        r_res_granted <= n_res_granted;
        r_res_exh     <= n_res_exh;
        r_res_taken   <= n_res_taken;
        if (w_load_out) begin
            r_out_granted <= r_res_granted;
            r_out_exh     <= r_res_exh;
            r_out_taken   <= r_res_taken;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_id    = r_out_granted;
    assign o_exhausted     = r_out_exh;
    assign o_release_taken = r_out_taken;

endmodule
